@@ sv/hex_lattice_cell_corners_top_assert.svh @@
// Assertion macros for the hexahedron lattice corner block.
// Used by the port checker; expects signals clk and rst in scope.
`ifndef HEX_LATTICE_CELL_CORNERS_TOP_ASSERT_SVH
`define HEX_LATTICE_CELL_CORNERS_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define HLCC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define HLCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define HLCC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hlcc_pkg.sv @@
// Shared widths, register codes, config bundle and helpers for the
// hexahedron lattice corner block. No dependencies.
`default_nettype none

package hlcc_pkg;

  localparam int IDX_W          = 30;   // cell number
  localparam int AXIS_W         = 11;   // cells per axis, also points per axis
  localparam int CORNER_W       = 31;   // point number
  localparam int ROW_W          = 21;   // z*py + j
  localparam int PLANE_W        = 21;   // px*py
  localparam int MAX_AXIS_CELLS = 1024;

  // divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = IDX_W / DIV_STEPS;

  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((8 * CORNER_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  typedef struct packed {
    logic [AXIS_W-1:0]  nx;
    logic [AXIS_W-1:0]  ny;
    logic [AXIS_W-1:0]  nz;
    logic [AXIS_W-1:0]  px;
    logic [AXIS_W-1:0]  py;
    logic [PLANE_W-1:0] pxpy;
    logic               nonempty;
  } cfg_t;

  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] v);
    if (32'(v) > MAX_AXIS_CELLS) begin
      return AXIS_W'(MAX_AXIS_CELLS);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/hlcc_cfg.sv @@
// Axis count registers with write saturation, plus derived point counts.
// Depends on hlcc_pkg.
`default_nettype none

module hlcc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hlcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlcc_pkg::AXIS_W-1:0]    cfg_data,
  output hlcc_pkg::cfg_t                 cfg
);

  logic [hlcc_pkg::AXIS_W-1:0]  nx, ny, nz;
  logic [hlcc_pkg::AXIS_W-1:0]  px, py;
  logic [hlcc_pkg::PLANE_W-1:0] pxpy;

  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= hlcc_pkg::AXIS_W'(1);
      ny <= hlcc_pkg::AXIS_W'(1);
      nz <= hlcc_pkg::AXIS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hlcc_pkg::REG_CELLS_X: nx <= hlcc_pkg::clamp_axis(cfg_data);
        hlcc_pkg::REG_CELLS_Y: ny <= hlcc_pkg::clamp_axis(cfg_data);
        hlcc_pkg::REG_CELLS_Z: nz <= hlcc_pkg::clamp_axis(cfg_data);
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign px = nx + hlcc_pkg::AXIS_W'(1);
  assign py = ny + hlcc_pkg::AXIS_W'(1);

  // plane size is registered, so it follows the axis registers in the next cycle; only used deep in the pipe
  always_ff @(posedge clk) begin
    pxpy <= hlcc_pkg::PLANE_W'(px) * hlcc_pkg::PLANE_W'(py);
  end

  assign cfg.nx       = nx;
  assign cfg.ny       = ny;
  assign cfg.nz       = nz;
  assign cfg.px       = px;
  assign cfg.py       = py;
  assign cfg.pxpy     = pxpy;
  assign cfg.nonempty = (nx != '0) && (ny != '0) && (nz != '0);

endmodule

`default_nettype wire

@@ sv/hlcc_div_stage.sv @@
// One stage of the pipelined restoring divider: DIV_STEPS quotient bits.
// Depends on hlcc_pkg.
`default_nettype none

module hlcc_div_stage #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hlcc_pkg::IDX_W-1:0]  in_acc,
  input  logic [hlcc_pkg::AXIS_W-1:0] in_rem,
  input  logic [SIDE_W-1:0]           in_side,
  input  logic [hlcc_pkg::AXIS_W-1:0] divisor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hlcc_pkg::IDX_W-1:0]  out_acc,
  output logic [hlcc_pkg::AXIS_W-1:0] out_rem,
  output logic [SIDE_W-1:0]           out_side
);

  logic                        valid;
  logic [hlcc_pkg::IDX_W-1:0]  acc_next;
  logic [hlcc_pkg::AXIS_W-1:0] rem_next;
  logic [hlcc_pkg::AXIS_W:0]   trial;
  logic                        ge;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // acc: remaining dividend bits at the top, quotient bits shift in below
  always_comb begin
    acc_next = in_acc;
    rem_next = in_rem;
    trial    = '0;
    ge       = 1'b0;
    for (int k = 0; k < hlcc_pkg::DIV_STEPS; k++) begin
      trial = {rem_next, acc_next[hlcc_pkg::IDX_W-1]};
      ge    = (trial >= {1'b0, divisor});
      if (ge) begin
        trial = trial - {1'b0, divisor};
      end
      rem_next = trial[hlcc_pkg::AXIS_W-1:0];
      acc_next = {acc_next[hlcc_pkg::IDX_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_acc  <= acc_next;
      out_rem  <= rem_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

@@ sv/hlcc_div.sv @@
// Pipelined divider of a cell-number-wide value by an axis count,
// DIV_STAGES stages, side data carried alongside. Depends on hlcc_pkg, hlcc_div_stage.
`default_nettype none

module hlcc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hlcc_pkg::IDX_W-1:0]  dividend,
  input  logic [SIDE_W-1:0]           in_side,
  input  logic [hlcc_pkg::AXIS_W-1:0] divisor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hlcc_pkg::IDX_W-1:0]  quotient,
  output logic [hlcc_pkg::AXIS_W-1:0] remainder,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int N = hlcc_pkg::DIV_STAGES;

  logic [N:0]                        v;
  logic [N:0]                        r;
  logic [N:0][hlcc_pkg::IDX_W-1:0]   acc;
  logic [N:0][hlcc_pkg::AXIS_W-1:0]  rem;
  logic [N:0][SIDE_W-1:0]            side;

  assign v[0]    = in_valid;
  assign in_ready = r[0];
  assign acc[0]  = dividend;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar g = 0; g < N; g++) begin : g_stage
    hlcc_div_stage #(.SIDE_W(SIDE_W)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_acc    (acc[g]),
      .in_rem    (rem[g]),
      .in_side   (side[g]),
      .divisor   (divisor),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_acc   (acc[g+1]),
      .out_rem   (rem[g+1]),
      .out_side  (side[g+1])
    );
  end

  assign r[N]      = out_ready;
  assign out_valid = v[N];
  assign quotient  = acc[N];
  assign remainder = rem[N];
  assign out_side  = side[N];

endmodule

`default_nettype wire

@@ sv/hlcc_corner.sv @@
// Range check and point arithmetic: z*py+j, then *px+i, then the eight
// corners into the output register. Depends on hlcc_pkg.
`default_nettype none

module hlcc_corner (
  input  logic                                clk,
  input  logic                                rst,
  input  hlcc_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hlcc_pkg::IDX_W-1:0]          z,
  input  logic [hlcc_pkg::AXIS_W-1:0]         j,
  input  logic [hlcc_pkg::AXIS_W-1:0]         i,
  input  logic                                nonempty,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hlcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [0:0]                          m_tuser
);

  localparam int W = hlcc_pkg::CORNER_W;

  // stage 1
  logic                        v1, ok1;
  logic [hlcc_pkg::ROW_W-1:0]  row1;
  logic [hlcc_pkg::AXIS_W-1:0] i1;
  logic                        r1;
  // stage 2
  logic                        v2, ok2;
  logic [W-1:0]                base2;
  logic                        r2;
  // stage 3, output register
  logic                        v3;
  logic                        r3;
  logic                        ok_next;
  logic [W-1:0]                top, px_w, pxpy_w;

  assign r3       = !v3 || m_tready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  assign ok_next = nonempty && (z < hlcc_pkg::IDX_W'(cfg.nz));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // z fits the axis width whenever the item is in range
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      ok1  <= ok_next;
      row1 <= hlcc_pkg::ROW_W'(z[hlcc_pkg::AXIS_W-1:0]) * hlcc_pkg::ROW_W'(cfg.py)
              + hlcc_pkg::ROW_W'(j);
      i1   <= i;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      ok2   <= ok1;
      base2 <= W'(row1) * W'(cfg.px) + W'(i1);
    end
  end

  assign px_w   = W'(cfg.px);
  assign pxpy_w = W'(cfg.pxpy);
  assign top    = base2 + pxpy_w;

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      m_tuser[0] <= ok2;
      if (ok2) begin
        m_tdata <= {top + px_w,   top + px_w + W'(1),   top + W'(1),   top,
                    base2 + px_w, base2 + px_w + W'(1), base2 + W'(1), base2};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  assign m_tvalid = v3;

endmodule

`default_nettype wire

@@ sv/hex_lattice_cell_corners_top.sv @@
// Hexahedron lattice cell corners. Each input item carries a linear cell
// number (x fastest, then y, then z); the block returns one result item with
// the eight point numbers of that cell, bottom ring counter-clockwise (base,
// base+1, base+px+1, base+px) and then the top ring px*py above, where
// px = cells_x+1 and py = cells_y+1. The flag in m_tuser is 1 when the cell
// lies in a non-empty lattice; otherwise all corners are 0. One item is taken
// per clock while the pipe is not stalled, through two 10-stage dividers (3 quotient
// bits per stage, set by the 30-bit cell number) then three arithmetic stages,
// the last being the output register. Every stage has its own valid bit and
// ready, so bubbles close up and the input keeps taking items while a result
// waits, until the whole pipe is full. Axis counts are written through the
// cfg port (index 0 x, 1 y, 2 z; values above 1024 saturate, other indices
// are ignored) and must only change while no item is in flight.
// Depends on hlcc_pkg, hlcc_cfg, hlcc_div, hlcc_corner.
`default_nettype none

module hex_lattice_cell_corners_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [hlcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlcc_pkg::AXIS_W-1:0]         cfg_data,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hlcc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [29:0] cell_index
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [30:0] corner_a, [61:31] corner_b, [92:62] corner_c, [123:93] corner_d,
  // [154:124] corner_e, [185:155] corner_f, [216:186] corner_g,
  // [247:217] corner_h
  output logic [hlcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [0:0]                          m_tuser    // [0] valid_res
);

  hlcc_pkg::cfg_t cfg;

  // first division: x remainder and the row-plane quotient
  logic                        d1_valid, d1_ready;
  logic [hlcc_pkg::IDX_W-1:0]  q1;
  logic [hlcc_pkg::AXIS_W-1:0] i_rem;
  logic                        d1_nonempty;

  // second division: y remainder and z
  logic                        d2_valid, d2_ready;
  logic [hlcc_pkg::IDX_W-1:0]  z_q;
  logic [hlcc_pkg::AXIS_W-1:0] j_rem;
  logic [hlcc_pkg::AXIS_W:0]   d2_side;

  hlcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // idx / nx ; the empty-lattice flag is taken with the item
  hlcc_div #(.SIDE_W(1)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .dividend  (s_tdata[hlcc_pkg::IDX_W-1:0]),
    .in_side   (cfg.nonempty),
    .divisor   (cfg.nx),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .quotient  (q1),
    .remainder (i_rem),
    .out_side  (d1_nonempty)
  );

  // (idx / nx) / ny ; i rides along
  hlcc_div #(.SIDE_W(hlcc_pkg::AXIS_W + 1)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_ready  (d1_ready),
    .dividend  (q1),
    .in_side   ({i_rem, d1_nonempty}),
    .divisor   (cfg.ny),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .quotient  (z_q),
    .remainder (j_rem),
    .out_side  (d2_side)
  );

  // z < nz is the same test as idx < nx*ny*nz
  hlcc_corner u_corner (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (d2_valid),
    .in_ready (d2_ready),
    .z        (z_q),
    .j        (j_rem),
    .i        (d2_side[hlcc_pkg::AXIS_W:1]),
    .nonempty (d2_side[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ sv/hlcc_check.sv @@
// Port-level checker for the hexahedron lattice corner block, bound to the
// top level. Depends on hlcc_pkg and hex_lattice_cell_corners_top_assert.svh.
`default_nettype none
`include "hex_lattice_cell_corners_top_assert.svh"

module hlcc_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [hlcc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [0:0]                       m_tuser
);

  `HLCC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
  `HLCC_ASSERT_RST(a_reset, rst, !m_tvalid, "result valid after reset")
  `HLCC_ASSERT(a_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "invalid cell with non-zero corners")
  `HLCC_ASSERT(a_next_x, m_tvalid && m_tuser[0], m_tdata[61:31] == 31'(m_tdata[30:0] + 31'd1), "corner b is not a plus one")
  `HLCC_ASSERT(a_plane, m_tvalid && m_tuser[0], 31'(m_tdata[154:124] - m_tdata[30:0]) == 31'(m_tdata[247:217] - m_tdata[123:93]), "top ring offset differs between corners")

endmodule

bind hex_lattice_cell_corners_top hlcc_check u_hlcc_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/sv/cell_corner_checker.sv @@
// Checker for the hexahedron lattice corner block: tracks the axis counts from
// the cfg port, predicts the corners of every accepted cell item and compares
// each result item. Depends on hlcc_pkg.
`default_nettype none

module cell_corner_checker
  import hlcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [AXIS_W-1:0]      cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [0:0]             m_tuser,
  output int                     pending,
  output int                     errors
);

  typedef struct packed {
    logic [IDX_W-1:0]             cell_no;
    logic [7:0][CORNER_W-1:0]     corner;   // a..h, a lowest
    logic                         in_lattice;
  } cell_corners_t;

  cell_corners_t     corners_q[$];
  logic [AXIS_W-1:0] nx, ny, nz;
  int                fails = 0;
  string             letters = "abcdefgh";

  assign errors = fails;

  task automatic report(input string msg);
    $display("[%0t] cell corners: %s", $time, msg);
    fails++;
  endtask

  // Split the cell number into x/y/z and wind the eight point numbers.
  function automatic cell_corners_t cell_corners(input logic [IDX_W-1:0] cell_no);
    logic [63:0]   ncells, px, py, ix, iy, iz, base, top;
    logic [63:0]   offs[4];
    cell_corners_t r;
    r = '0;
    r.cell_no = cell_no;
    ncells = 64'(nx) * 64'(ny) * 64'(nz);
    if (ncells == 0 || 64'(cell_no) >= ncells) begin
      return r;   // empty lattice or index past the end: all zero
    end
    px   = 64'(nx) + 1;
    py   = 64'(ny) + 1;
    ix   = 64'(cell_no) % 64'(nx);
    iy   = (64'(cell_no) / 64'(nx)) % 64'(ny);
    iz   = 64'(cell_no) / (64'(nx) * 64'(ny));
    base = (iz * py + iy) * px + ix;
    top  = base + px * py;
    offs = '{64'd0, 64'd1, px + 1, px};
    for (int k = 0; k < 4; k++) begin
      r.corner[k]     = CORNER_W'(base + offs[k]);
      r.corner[k + 4] = CORNER_W'(top + offs[k]);
    end
    r.in_lattice = 1'b1;
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] sat_count(input logic [AXIS_W-1:0] v);
    return (32'(v) > MAX_AXIS_CELLS) ? AXIS_W'(MAX_AXIS_CELLS) : v;
  endfunction

  always @(posedge clk) begin
    cell_corners_t want;
    if (rst) begin
      nx = AXIS_W'(1);
      ny = AXIS_W'(1);
      nz = AXIS_W'(1);
      corners_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELLS_X: nx = sat_count(cfg_data);
          REG_CELLS_Y: ny = sat_count(cfg_data);
          REG_CELLS_Z: nz = sat_count(cfg_data);
          default: ;  // unknown index: ignored
        endcase
      end
      if (s_tvalid && s_tready) begin
        corners_q.push_back(cell_corners(s_tdata[IDX_W-1:0]));
      end
      if (m_tvalid && m_tready) begin
        if (corners_q.size() == 0) begin
          report("result item with no cell outstanding");
        end else begin
          want = corners_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (m_tdata[k*CORNER_W +: CORNER_W] !== want.corner[k]) begin
              report($sformatf("cell %0d corner_%c got %0d want %0d", want.cell_no,
                               letters[k], m_tdata[k*CORNER_W +: CORNER_W],
                               want.corner[k]));
            end
          end
          if (m_tuser[0] !== want.in_lattice) begin
            report($sformatf("cell %0d valid_res got %b want %b", want.cell_no,
                             m_tuser[0], want.in_lattice));
          end
        end
      end
    end
    pending <= corners_q.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_hex_lattice_cell_corners_top.sv @@
// Testbench top for hex_lattice_cell_corners_top: clock, reset, cell item
// stimulus, random back-pressure and the verdict.
// Depends on hlcc_pkg, cell_corner_checker and the block itself.
`default_nettype none

module tb_hex_lattice_cell_corners_top;
  import hlcc_pkg::*;

  localparam int                   ITEMS_PER_PHASE = 200;
  localparam int                   RANDOM_PHASES   = 8;
  localparam int                   DRAIN_CYCLES    = 30;    // full pipe depth plus margin
  localparam int                   LONG_HOLD       = 150;   // well past the pipe depth
  localparam int                   IDLE_LIMIT      = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [AXIS_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // [29:0] cell_index
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;    // corner_a .. corner_h, 31 bits each
  logic [0:0]             m_tuser;    // [0] valid_res

  int pending;
  int errors;
  int idle_cycles;

  // stimulus-side view of the lattice, used to aim cell numbers
  logic [AXIS_W-1:0] lat_x, lat_y, lat_z;
  logic [63:0]       lat_cells;

  bit steady   = 1'b0;   // no gaps on either side
  int hold_req = 0;      // bumped to ask the receiver for one long hold-off

  hex_lattice_cell_corners_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  cell_corner_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AXIS_W-1:0] axis_count(input logic [AXIS_W-1:0] raw);
    return (32'(raw) > MAX_AXIS_CELLS) ? AXIS_W'(MAX_AXIS_CELLS) : raw;
  endfunction

  // Raw register value: mostly small lattices, some wide ones, a few that
  // saturate and a few empty axes.
  function automatic logic [AXIS_W-1:0] pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return AXIS_W'($urandom_range(1, 6));
    if (r < 70) return AXIS_W'($urandom_range(7, 64));
    if (r < 85) return AXIS_W'($urandom_range(65, 1023));
    if (r < 92) return AXIS_W'(MAX_AXIS_CELLS);
    if (r < 97) return AXIS_W'($urandom_range(1025, 2047));
    return '0;
  endfunction

  // Mostly cells inside the lattice, then its two ends, just past the end,
  // and raw 30-bit noise.
  function automatic logic [IDX_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (lat_cells != 0 && r < 70) return IDX_W'($urandom_range(0, 32'(lat_cells - 1)));
    if (lat_cells != 0 && r < 75) return '0;
    if (lat_cells != 0 && r < 80) return IDX_W'(lat_cells - 1);
    if (r < 90) return IDX_W'(lat_cells + 64'($urandom_range(0, 3)));
    return IDX_W'($urandom);
  endfunction

  // Offer one cell item and hold it until taken. valid stays high between
  // back-to-back items.
  task automatic send_cell(input logic [IDX_W-1:0] cell_no);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(cell_no);
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Axis counts only change with the pipe empty. The extra write to the
  // unused index must leave the lattice alone.
  task automatic set_lattice(input logic [AXIS_W-1:0] rx, ry, rz);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CELLS_X;
    cfg_data  <= rx;
    @(posedge clk);
    cfg_index <= REG_CELLS_Y;
    cfg_data  <= ry;
    @(posedge clk);
    cfg_index <= REG_CELLS_Z;
    cfg_data  <= rz;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= AXIS_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    lat_x     = axis_count(rx);
    lat_y     = axis_count(ry);
    lat_z     = axis_count(rz);
    lat_cells = 64'(lat_x) * 64'(lat_y) * 64'(lat_z);
  endtask

  // Receiver: ready runs broken by stalls, a long hold-off on request, or
  // always ready during steady phases.
  initial begin
    int hold_seen;
    int gap;
    hold_seen = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: too long with no handshake and no register write ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** hex_lattice_cell_corners_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CELLS_X;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    lat_x     = AXIS_W'(1);
    lat_y     = AXIS_W'(1);
    lat_z     = AXIS_W'(1);
    lat_cells = 64'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset lattice is a single cell: only cell 0 lies inside
    send_cell(IDX_W'(0));
    send_cell(IDX_W'(1));
    send_cell(IDX_W'(30'h3FFF_FFFF));

    // over-range writes saturate: 1024 on every axis, so every 30-bit
    // number is a cell and the corners reach their widest
    set_lattice(11'd2047, 11'd1025, 11'd1024);
    send_cell(IDX_W'(0));
    send_cell(IDX_W'(1023));
    send_cell(IDX_W'(1024));
    send_cell(IDX_W'(30'h000F_FFFF));
    send_cell(IDX_W'(30'h0010_0000));
    send_cell(IDX_W'(30'h2AAA_AAAA));
    send_cell(IDX_W'(30'h1555_5555));
    send_cell(IDX_W'(30'h3FFF_FFFF));

    // empty lattice: zero cells along x
    set_lattice(11'd0, 11'd5, 11'd7);
    send_cell(IDX_W'(0));
    send_cell(IDX_W'(3));

    // uneven lattice: row and plane wraps, last cell and one past it
    set_lattice(11'd3, 11'd4, 11'd5);
    send_cell(IDX_W'(0));
    send_cell(IDX_W'(2));
    send_cell(IDX_W'(3));
    send_cell(IDX_W'(12));
    send_cell(IDX_W'(59));
    send_cell(IDX_W'(60));

    // --- random phases ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_lattice(AXIS_W'($urandom_range(1024, 2047)),
                       AXIS_W'($urandom_range(1024, 2047)),
                       AXIS_W'($urandom_range(1024, 2047)));
        1: set_lattice(AXIS_W'($urandom_range(1, 3)), AXIS_W'($urandom_range(1, 3)),
                       AXIS_W'($urandom_range(1, 3)));
        default: set_lattice(pick_axis(), pick_axis(), pick_axis());
      endcase
      steady = (ph == 2 || ph == 5);
      // receiver holds off while the sender keeps offering: the pipe fills
      // and the input has to stall
      if (ph == 2) hold_req++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cell(pick_cell());
      end
    end
    steady = 1'b0;

    drain();
    if (errors == 0) begin
      $display("** hex_lattice_cell_corners_top: PASSED **");
    end else begin
      $display("** hex_lattice_cell_corners_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
